### sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted while reset is asserted.
`define CFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfa assertion failed");

// Next-cycle implication, muted while reset is asserted.
`define CFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfa assertion failed");

// Next-cycle implication that also holds across reset.
`define CFA_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("cfa assertion failed");

`endif

### sv/cfa_pkg.sv
package cfa_pkg;

    localparam int MAX_FRAMES = 1024;
    localparam int IDX_W      = $clog2(MAX_FRAMES);
    localparam int SZ_W       = (IDX_W + 1 > 11) ? IDX_W + 1 : 11;

    localparam int FRAME_W    = 20;
    localparam int COUNT_W    = 11;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 3;
    localparam int FSTATE_W   = 2;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 1;

    // Pool size in use right after reset: min(1024, MAX_FRAMES).
    localparam logic [SZ_W-1:0] RESET_SIZE =
        SZ_W'((MAX_FRAMES < 1024) ? MAX_FRAMES : 1024);

    // Per-frame state codes.
    localparam logic [FSTATE_W-1:0] ST_FREE  = 2'd0;
    localparam logic [FSTATE_W-1:0] ST_ALLOC = 2'd1;
    localparam logic [FSTATE_W-1:0] ST_HEAD  = 2'd2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_MARK    = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] RC_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] RC_NOSPACE = 3'd1;
    localparam logic [STATUS_W-1:0] RC_NOTHEAD = 3'd2;
    localparam logic [STATUS_W-1:0] RC_RANGE   = 3'd3;
    localparam logic [STATUS_W-1:0] RC_ZERO    = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE = 1'd1;

    // Pool settings and clearing-sweep status handed to the sequencer.
    typedef struct packed {
        logic [FRAME_W-1:0] base;
        logic [SZ_W-1:0]    size;
        logic               clearing;
        logic [IDX_W-1:0]   clr_addr;
        logic               reload;
    } t_pool;

endpackage

### sv/cfa_req_if.sv
interface cfa_req_if;
    import cfa_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [FRAME_W-1:0] frame;
    logic [COUNT_W-1:0] count;

    modport source (output valid, op, frame, count, input ready);
    modport sink   (input valid, op, frame, count, output ready);
endinterface

### sv/cfa_rsp_if.sv
interface cfa_rsp_if;
    import cfa_pkg::*;

    logic                valid;
    logic                ready;
    logic [FRAME_W-1:0]  head_frame;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  frames_free;

    modport source (output valid, head_frame, status, frames_free, input ready);
    modport sink   (input valid, head_frame, status, frames_free, output ready);
endinterface

### sv/cfa_ram.sv
module cfa_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/cfa_cfg.sv
module cfa_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cfa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cfa_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output cfa_pkg::t_pool                 o_pool
);
    import cfa_pkg::*;

    logic [FRAME_W-1:0] r_base,     n_base;
    logic [SZ_W-1:0]    r_size,     n_size;
    logic               r_clearing, n_clearing;
    logic [IDX_W-1:0]   r_clr_addr, n_clr_addr;
    logic               r_reload,   n_reload;
    logic [SZ_W-1:0]    wr_size;

    // The pool never grows past the frame store.
    assign wr_size = (SZ_W'(i_cfg_wdata[COUNT_W-1:0]) > SZ_W'(MAX_FRAMES)) ?
                     SZ_W'(MAX_FRAMES) : SZ_W'(i_cfg_wdata[COUNT_W-1:0]);

    always_comb begin
        n_base     = r_base;
        n_size     = r_size;
        n_clearing = r_clearing;
        n_clr_addr = r_clr_addr;
        n_reload   = 1'b0;

        if (r_clearing) begin
            n_clr_addr = r_clr_addr + 1'b1;
            if (r_clr_addr == IDX_W'(MAX_FRAMES - 1)) begin
                n_clearing = 1'b0;
            end
        end

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_POOL_BASE: begin
                    n_base = i_cfg_wdata[FRAME_W-1:0];
                end
                REG_POOL_SIZE: begin
                    n_size     = wr_size;
                    n_clearing = 1'b1;
                    n_clr_addr = '0;
                    n_reload   = 1'b1;
                end
                default: begin
                    n_base = r_base;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= '0;
            r_size     <= RESET_SIZE;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_reload   <= 1'b0;
        end else begin
            r_base     <= n_base;
            r_size     <= n_size;
            r_clearing <= n_clearing;
            r_clr_addr <= n_clr_addr;
            r_reload   <= n_reload;
        end
    end

    assign o_pool.base     = r_base;
    assign o_pool.size     = r_size;
    assign o_pool.clearing = r_clearing;
    assign o_pool.clr_addr = r_clr_addr;
    assign o_pool.reload   = r_reload;

endmodule

### sv/cfa_ctrl.sv
module cfa_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cfa_pkg::t_pool                i_pool,
    cfa_req_if.sink                       i_req,
    cfa_rsp_if.source                     o_rsp,
    output logic                          o_ram_we,
    output logic [cfa_pkg::IDX_W-1:0]     o_ram_waddr,
    output logic [cfa_pkg::FSTATE_W-1:0]  o_ram_wdata,
    output logic [cfa_pkg::IDX_W-1:0]     o_ram_raddr,
    input  logic [cfa_pkg::FSTATE_W-1:0]  i_ram_rdata
);
    import cfa_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_CHK   = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_REL   = 3'd4;
    localparam logic [2:0] S_CLAIM = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]          r_state,   n_state;
    logic [OP_W-1:0]     r_op,      n_op;
    logic [FRAME_W-1:0]  r_frame,   n_frame;
    logic [COUNT_W-1:0]  r_count,   n_count;
    logic [FRAME_W-1:0]  r_rel,     n_rel;
    logic                r_lo,      n_lo;
    logic [SZ_W-1:0]     r_ptr,     n_ptr;
    logic [SZ_W-1:0]     r_end,     n_end;
    logic [SZ_W-1:0]     r_dptr,    n_dptr;
    logic                r_dv,      n_dv;
    logic [SZ_W-1:0]     r_run,     n_run;
    logic                r_first,   n_first;
    logic [SZ_W-1:0]     r_waddr,   n_waddr;
    logic [SZ_W-1:0]     r_left,    n_left;
    logic [SZ_W-1:0]     r_start,   n_start;
    logic [SZ_W-1:0]     r_free,    n_free;
    logic [STATUS_W-1:0] r_status,  n_status;
    logic [FRAME_W-1:0]  r_head,    n_head;
    logic                r_ovalid,  n_ovalid;
    logic [FRAME_W-1:0]  r_ohead,   n_ohead;
    logic [STATUS_W-1:0] r_ostatus, n_ostatus;
    logic [COUNT_W-1:0]  r_ofree,   n_ofree;

    logic [SZ_W-1:0] cnt_x;
    logic [SZ_W-1:0] rel_s;
    logic            rel_in;
    logic [SZ_W-1:0] run_inc;
    logic [SZ_W-1:0] run_start;
    logic            we_fsm;
    logic [IDX_W-1:0] waddr_fsm;
    logic [FSTATE_W-1:0] wdata_fsm;

    assign cnt_x     = SZ_W'(r_count);
    assign rel_s     = SZ_W'(r_rel);
    assign rel_in    = (r_rel < FRAME_W'(i_pool.size));
    assign run_inc   = r_run + 1'b1;
    assign run_start = r_dptr + 1'b1 - cnt_x;

    assign i_req.ready = (r_state == S_IDLE) && !i_pool.clearing;

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_frame   = r_frame;
        n_count   = r_count;
        n_rel     = r_rel;
        n_lo      = r_lo;
        n_ptr     = r_ptr;
        n_end     = r_end;
        n_dptr    = r_dptr;
        n_dv      = r_dv;
        n_run     = r_run;
        n_first   = r_first;
        n_waddr   = r_waddr;
        n_left    = r_left;
        n_start   = r_start;
        n_free    = r_free;
        n_status  = r_status;
        n_head    = r_head;
        n_ovalid  = r_ovalid && !o_rsp.ready;
        n_ohead   = r_ohead;
        n_ostatus = r_ostatus;
        n_ofree   = r_ofree;
        we_fsm    = 1'b0;
        waddr_fsm = r_waddr[IDX_W-1:0];
        wdata_fsm = ST_FREE;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid && !i_pool.clearing) begin
                    n_op    = i_req.op;
                    n_frame = i_req.frame;
                    n_count = i_req.count;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_rel   = r_frame - i_pool.base;
                n_lo    = (r_frame < i_pool.base);
                n_state = S_CHK;
            end
            S_CHK: begin
                n_head  = '0;
                n_dv    = 1'b0;
                n_run   = '0;
                n_first = 1'b1;
                n_state = S_DONE;
                case (r_op)
                    OP_ALLOC: begin
                        if (r_count == '0) begin
                            n_status = RC_ZERO;
                        end else if (cnt_x > r_free || cnt_x > i_pool.size) begin
                            n_status = RC_NOSPACE;
                        end else begin
                            n_ptr   = '0;
                            n_end   = i_pool.size;
                            n_state = S_SCAN;
                        end
                    end
                    OP_RELEASE: begin
                        if (r_lo || !rel_in) begin
                            n_status = RC_RANGE;
                        end else begin
                            n_ptr   = rel_s;
                            n_state = S_REL;
                        end
                    end
                    OP_MARK: begin
                        if (r_count == '0) begin
                            n_status = RC_ZERO;
                        end else if (r_lo || !rel_in || cnt_x > i_pool.size - rel_s) begin
                            n_status = RC_RANGE;
                        end else begin
                            n_ptr   = rel_s;
                            n_end   = rel_s + cnt_x;
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                        n_status = RC_RANGE;
                    end
                endcase
            end
            S_SCAN: begin
                // Reads stream one entry ahead of the evaluation of the data.
                if (r_ptr < r_end) begin
                    n_ptr  = r_ptr + 1'b1;
                    n_dv   = 1'b1;
                    n_dptr = r_ptr;
                end else begin
                    n_dv = 1'b0;
                end
                if (r_dv) begin
                    if (r_op == OP_ALLOC) begin
                        if (i_ram_rdata == ST_FREE) begin
                            n_run = run_inc;
                            if (run_inc == cnt_x) begin
                                n_start = run_start;
                                n_waddr = run_start;
                                n_left  = cnt_x;
                                n_dv    = 1'b0;
                                n_state = S_CLAIM;
                            end
                        end else begin
                            n_run = '0;
                        end
                    end else if (i_ram_rdata != ST_FREE) begin
                        n_status = RC_NOSPACE;
                        n_dv     = 1'b0;
                        n_state  = S_DONE;
                    end
                end else if (r_ptr >= r_end) begin
                    n_dv = 1'b0;
                    if (r_op == OP_ALLOC) begin
                        n_status = RC_NOSPACE;
                        n_state  = S_DONE;
                    end else begin
                        n_start = rel_s;
                        n_waddr = rel_s;
                        n_left  = cnt_x;
                        n_state = S_CLAIM;
                    end
                end
            end
            S_REL: begin
                if (r_ptr < i_pool.size) begin
                    n_ptr  = r_ptr + 1'b1;
                    n_dv   = 1'b1;
                    n_dptr = r_ptr;
                end else begin
                    n_dv = 1'b0;
                end
                waddr_fsm = r_dptr[IDX_W-1:0];
                if (r_dv) begin
                    if (r_first) begin
                        if (i_ram_rdata != ST_HEAD) begin
                            n_status = RC_NOTHEAD;
                            n_dv     = 1'b0;
                            n_state  = S_DONE;
                        end else begin
                            we_fsm  = 1'b1;
                            n_free  = r_free + 1'b1;
                            n_first = 1'b0;
                        end
                    end else if (i_ram_rdata == ST_ALLOC) begin
                        we_fsm = 1'b1;
                        n_free = r_free + 1'b1;
                    end else begin
                        n_status = RC_OK;
                        n_head   = r_frame;
                        n_dv     = 1'b0;
                        n_state  = S_DONE;
                    end
                end else if (!r_first && r_ptr >= i_pool.size) begin
                    n_status = RC_OK;
                    n_head   = r_frame;
                    n_state  = S_DONE;
                end
            end
            S_CLAIM: begin
                we_fsm    = 1'b1;
                wdata_fsm = r_first ? ST_HEAD : ST_ALLOC;
                n_first   = 1'b0;
                n_waddr   = r_waddr + 1'b1;
                n_left    = r_left - 1'b1;
                if (r_left == SZ_W'(1)) begin
                    n_free   = r_free - cnt_x;
                    n_status = RC_OK;
                    n_head   = (r_op == OP_ALLOC) ?
                               i_pool.base + FRAME_W'(r_start) : r_frame;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid  = 1'b1;
                    n_ohead   = r_head;
                    n_ostatus = r_status;
                    n_ofree   = COUNT_W'(r_free);
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_pool.reload) begin
            n_free = i_pool.size;
        end
    end

    // The clearing sweep owns the write port; no new item is accepted during it.
    always_comb begin
        if (i_pool.clearing) begin
            o_ram_we    = 1'b1;
            o_ram_waddr = i_pool.clr_addr;
            o_ram_wdata = ST_FREE;
        end else begin
            o_ram_we    = we_fsm;
            o_ram_waddr = waddr_fsm;
            o_ram_wdata = wdata_fsm;
        end
    end

    assign o_ram_raddr = r_ptr[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_dv     <= 1'b0;
            r_free   <= RESET_SIZE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_dv     <= n_dv;
            r_free   <= n_free;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_frame   <= n_frame;
        r_count   <= n_count;
        r_rel     <= n_rel;
        r_lo      <= n_lo;
        r_ptr     <= n_ptr;
        r_end     <= n_end;
        r_dptr    <= n_dptr;
        r_run     <= n_run;
        r_first   <= n_first;
        r_waddr   <= n_waddr;
        r_left    <= n_left;
        r_start   <= n_start;
        r_status  <= n_status;
        r_head    <= n_head;
        r_ohead   <= n_ohead;
        r_ostatus <= n_ostatus;
        r_ofree   <= n_ofree;
    end

    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.head_frame  = r_ohead;
    assign o_rsp.status      = r_ostatus;
    assign o_rsp.frames_free = r_ofree;

endmodule

### sv/contiguous_frame_allocator_top.sv
// An allocate scans the pool for the first free run and then claims its frames; a mark
// checks that its range is free and then claims it; a release walks the run from its head.
// Throughput: one item at a time, bounded by the single frame-state memory port
// that the scan, claim and release walk step through at one entry per cycle.
// Reset (synchronous, active low) and every pool_size write start a clearing pass
// that sets every frame free; no item is accepted during it.
module contiguous_frame_allocator_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    cfa_req_if.sink                        i_req,
    cfa_rsp_if.source                      o_rsp,
    input  logic                           i_cfg_we,
    input  logic [cfa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cfa_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import cfa_pkg::*;

    // The frame table lives in one simple dual-port memory with a registered
    // read. The sequencer reads one entry per cycle and evaluates it in the
    // following cycle; writes always land on entries already read, so no read ever
    // overlaps a pending write to the same entry and no forwarding is needed.
    // Items are fully serialized, which keeps writes of one item ahead of the
    // reads of the next.

    t_pool                pool;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [FSTATE_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [FSTATE_W-1:0]  ram_rdata;

    // Configuration registers and the clearing sweep.
    cfa_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_pool      (pool)
    );

    // Frame-state store: two bits per frame (free, allocated, head).
    cfa_ram #(
        .WIDTH (FSTATE_W),
        .DEPTH (MAX_FRAMES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Sequencer: range checks, first-fit scan, claim and release walks, and
    // the output register that holds a finished item until it is taken.
    cfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pool      (pool),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

endmodule

### sv/cfa_checker.sv
`include "assert_macros.svh"

module cfa_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_ready,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [cfa_pkg::FRAME_W-1:0]   i_rsp_head_frame,
    input logic [cfa_pkg::STATUS_W-1:0]  i_rsp_status,
    input logic [cfa_pkg::COUNT_W-1:0]   i_rsp_frames_free
);
    import cfa_pkg::*;

    // A result waiting at the output stays until it is taken.
    `CFA_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid)

    // Every failing item reports frame zero.
    `CFA_ASSERT_IMP(a_fail_head_zero, i_clk, i_rst_n, i_rsp_valid && (i_rsp_status != RC_OK), i_rsp_head_frame == '0)

    // Only defined status codes leave the block.
    `CFA_ASSERT_IMP(a_status_code, i_clk, i_rst_n, i_rsp_valid, (i_rsp_status == RC_OK) || (i_rsp_status == RC_NOSPACE) || (i_rsp_status == RC_NOTHEAD) || (i_rsp_status == RC_RANGE) || (i_rsp_status == RC_ZERO))

    // The free count never exceeds the frame store.
    `CFA_ASSERT_IMP(a_free_bound, i_clk, i_rst_n, i_rsp_valid, 32'(i_rsp_frames_free) <= 32'(MAX_FRAMES))

    // Reset starts the clearing pass, so no item is taken right after it.
    `CFA_ASSERT_NEXT_ALWAYS(a_clear_after_reset, i_clk, !i_rst_n, !i_req_ready)

endmodule

bind contiguous_frame_allocator_top cfa_checker u_cfa_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_head_frame  (o_rsp.head_frame),
    .i_rsp_status      (o_rsp.status),
    .i_rsp_frames_free (o_rsp.frames_free)
);
